[rtl/core/bbpd_pkg.sv]
// Shared types and constants for the ball-beam PD servo controller.
`timescale 1ns / 1ps
`default_nettype none
package bbpd_pkg;

    typedef enum logic [3:0] {
        STEP_TD,
        STEP_KP,
        STEP_G,
        STEP_SPAN,
        STEP_D180,
        STEP_SENS,
        STEP_PF,
        STEP_V1000,
        STEP_VDIV,
        STEP_VF
    } step_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        CFG_DESIRED,
        CFG_KP,
        CFG_TD,
        CFG_POS_ALPHA,
        CFG_SPD_ALPHA,
        CFG_SOURCE,
        CFG_DUTY_MIN,
        CFG_DUTY_MAX
    } cfg_idx_t;

    typedef struct packed {
        logic  load;
        logic  start;
        logic  finish;
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_busy;
    } status_t;

    localparam int MUL_W = 64;
    localparam int MB_W  = 24;
    localparam int DIV_W = 48;
    localparam int DEN_W = 32;
    localparam int CFG_W = 24;
    localparam int OUT_W = 72;

    localparam logic [MB_W-1:0] G_Q16     = 24'd642908;
    localparam logic [MB_W-1:0] K_MS      = 24'd1000;
    // ceil(2^28 / 45): exact x/45 for x below 2^22 after a 28-bit shift
    localparam logic [MB_W-1:0] K_R45     = 24'd5965233;
    localparam logic signed [MUL_W-1:0] K_DEG     = 64'sd180;
    localparam logic signed [MUL_W-1:0] ANGLE_SAT = 64'sd4398046511104;
    localparam logic signed [MUL_W-1:0] K_MID     = 64'sd88;

    localparam logic [23:0] RST_DESIRED   = 24'd25600;
    localparam logic [15:0] RST_KP        = 16'd2294;
    localparam logic [15:0] RST_TD        = 16'd2458;
    localparam logic [15:0] RST_POS_ALPHA = 16'd10923;
    localparam logic [15:0] RST_SPD_ALPHA = 16'd6554;
    localparam logic [15:0] RST_DUTY_MIN  = 16'd1638;
    localparam logic [15:0] RST_DUTY_MAX  = 16'd8192;

endpackage
`default_nettype wire

[rtl/core/bbpd_mul.sv]
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier.
`timescale 1ns / 1ps
`default_nettype none
module bbpd_mul (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [bbpd_pkg::MUL_W-1:0]     a_in,
    input  wire logic        [bbpd_pkg::MB_W-1:0]      b_in,
    output logic signed      [bbpd_pkg::MUL_W-1:0]     product,
    output logic                                       done
);
    localparam int CW = $clog2(bbpd_pkg::MB_W);
    localparam logic [CW-1:0] LAST = CW'(bbpd_pkg::MB_W - 1);

    logic signed [bbpd_pkg::MUL_W-1:0] a_reg, acc_reg;
    logic        [bbpd_pkg::MB_W-1:0]  b_reg;
    logic        [CW-1:0]              cnt_reg;
    logic                              busy_reg, done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a_in;
            b_reg   <= b_in;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg <<< 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign product = acc_reg;
    assign done    = done_reg;
endmodule
`default_nettype wire

[rtl/core/bbpd_div.sv]
// Restoring serial divider, signed numerator over positive divisor, trunc or floor.
`timescale 1ns / 1ps
`default_nettype none
module bbpd_div (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic                                  floor_mode,
    input  wire logic signed [bbpd_pkg::MUL_W-1:0]     num,
    input  wire logic        [bbpd_pkg::DEN_W-1:0]     den,
    output logic signed      [bbpd_pkg::MUL_W-1:0]     quotient,
    output logic                                       done
);
    localparam int DW = bbpd_pkg::DIV_W;
    localparam int NW = bbpd_pkg::DEN_W;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST = CW'(DW - 1);
    localparam int MUL_W_L = bbpd_pkg::MUL_W;

    logic [DW-1:0]    quo_reg;
    logic [NW-1:0]    rem_reg, den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg, neg_reg, floor_reg;

    logic signed [MUL_W_L-1:0] num_mag;
    logic [NW:0]               trial, diff;
    logic                      fits;
    logic signed [MUL_W_L-1:0] q_mag, q_sgn;

    assign num_mag = num[MUL_W_L-1] ? -num : num;
    assign trial   = {rem_reg, quo_reg[DW-1]};
    assign diff    = trial - {1'b0, den_reg};
    assign fits    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg   <= num_mag[DW-1:0];
            rem_reg   <= '0;
            den_reg   <= den;
            neg_reg   <= num[MUL_W_L-1];
            floor_reg <= floor_mode;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[NW-1:0] : trial[NW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign q_mag = $signed({{(MUL_W_L-DW){1'b0}}, quo_reg});
    assign q_sgn = neg_reg ? -q_mag : q_mag;
    // floor rounds a negative inexact quotient one further down
    assign quotient = (floor_reg && neg_reg && (rem_reg != '0)) ? q_sgn - 1 : q_sgn;
    assign done     = done_reg;
endmodule
`default_nettype wire

[rtl/core/bbpd_datapath.sv]
// Datapath: config registers, filter state, serial arithmetic units, result register.
`timescale 1ns / 1ps
`default_nettype none
module bbpd_datapath #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bbpd_pkg::cmd_t                cmd,
    output bbpd_pkg::status_t                  status,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_addr,
    input  wire logic [bbpd_pkg::CFG_W-1:0]    cfg_wdata,
    input  wire logic [ADC_BITS-1:0]           adc_sample,
    input  wire logic [15:0]                   elapsed_ms,
    input  wire logic [23:0]                   ext_position,
    input  wire logic                          ext_valid,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bbpd_pkg::OUT_W-1:0]         m_tdata
);
    localparam int MW = bbpd_pkg::MUL_W;
    localparam longint FS_L = (64'sd1 <<< ADC_BITS) - 64'sd1;
    localparam longint NUM0 = 64'sd55500 * FS_L;
    localparam longint FS13 = 64'sd13 * FS_L;

    function automatic logic signed [MW-1:0] sat_s(input logic signed [MW-1:0] x,
                                                   input logic signed [MW-1:0] lo,
                                                   input logic signed [MW-1:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    localparam logic signed [MW-1:0] P24_MAX = 64'sd8388607;
    localparam logic signed [MW-1:0] P24_MIN = -64'sd8388608;
    localparam logic signed [MW-1:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [MW-1:0] S32_MIN = -64'sd2147483648;

    // config
    logic signed [23:0] desired_reg;
    logic [15:0] kp_reg, td_reg, pa_reg, sa_reg, dmin_reg, dmax_reg;
    logic        src_reg;

    // state and working registers
    logic signed [23:0] pos_reg, prev_reg, raw_reg, ext_reg;
    logic signed [31:0] spd_reg;
    logic signed [MW-1:0] acc_reg;
    logic [15:0] duty_reg, el_reg;
    logic [ADC_BITS-1:0] adc_reg;
    logic        extv_reg;
    bbpd_pkg::step_t step_reg;
    logic        out_valid_reg;
    logic [bbpd_pkg::OUT_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            desired_reg <= bbpd_pkg::RST_DESIRED;
            kp_reg      <= bbpd_pkg::RST_KP;
            td_reg      <= bbpd_pkg::RST_TD;
            pa_reg      <= bbpd_pkg::RST_POS_ALPHA;
            sa_reg      <= bbpd_pkg::RST_SPD_ALPHA;
            src_reg     <= 1'b0;
            dmin_reg    <= bbpd_pkg::RST_DUTY_MIN;
            dmax_reg    <= bbpd_pkg::RST_DUTY_MAX;
        end else if (cfg_we) begin
            unique case (bbpd_pkg::cfg_idx_t'(cfg_addr))
                bbpd_pkg::CFG_DESIRED:   desired_reg <= cfg_wdata;
                bbpd_pkg::CFG_KP:        kp_reg      <= cfg_wdata[15:0];
                bbpd_pkg::CFG_TD:        td_reg      <= cfg_wdata[15:0];
                bbpd_pkg::CFG_POS_ALPHA: pa_reg      <= cfg_wdata[15:0];
                bbpd_pkg::CFG_SPD_ALPHA: sa_reg      <= cfg_wdata[15:0];
                bbpd_pkg::CFG_SOURCE:    src_reg     <= cfg_wdata[0];
                bbpd_pkg::CFG_DUTY_MIN:  dmin_reg    <= cfg_wdata[15:0];
                bbpd_pkg::CFG_DUTY_MAX:  dmax_reg    <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // derivative term: d20 = e*4096 - speed*td, floored back to Q8
    logic signed [24:0] err;
    logic signed [50:0] d20;
    logic signed [38:0] d8;
    assign err = 25'(desired_reg) - 25'(pos_reg);
    assign d20 = $signed({{14{err[24]}}, err, 12'b0}) - acc_reg[50:0];
    assign d8  = d20[50:12];

    logic signed [16:0] span;
    logic [15:0]        span_mag;
    assign span     = $signed({1'b0, dmax_reg}) - $signed({1'b0, dmin_reg});
    assign span_mag = span[16] ? 16'(-span) : span[15:0];

    // sensor conversion: d = adc*330 - 13*FS, raw = floor(256*(55500*FS - 184*d) / (5*d))
    logic signed [31:0] sens_d;
    logic signed [47:0] sens_num;
    logic               sens_pos;
    assign sens_d   = $signed(32'(adc_reg) * 32'd330) - 32'(FS13);
    assign sens_num = (48'(NUM0) - 48'(sens_d) * 48'sd184) <<< 8;
    assign sens_pos = (sens_d > 0);

    logic signed [MW-1:0] mul_a, mul_p, div_n, div_q;
    logic [bbpd_pkg::MB_W-1:0]  mul_b;
    logic [bbpd_pkg::DEN_W-1:0] div_d;
    logic mul_start, div_start, div_floor, mul_done, div_done;

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_n     = '0;
        div_d     = 32'd1;
        div_floor = 1'b0;
        mul_start = 1'b0;
        div_start = 1'b0;
        unique case (cmd.step)
            bbpd_pkg::STEP_TD: begin
                mul_a = MW'(spd_reg);
                mul_b = bbpd_pkg::MB_W'(td_reg);
                mul_start = cmd.start;
            end
            bbpd_pkg::STEP_KP: begin
                mul_a = MW'(d8);
                mul_b = bbpd_pkg::MB_W'(kp_reg);
                mul_start = cmd.start;
            end
            bbpd_pkg::STEP_G: begin
                mul_a = acc_reg;
                mul_b = bbpd_pkg::G_Q16;
                mul_start = cmd.start;
            end
            bbpd_pkg::STEP_SPAN: begin
                // past either end of travel the duty only goes further into its clamp
                mul_a = sat_s(bbpd_pkg::K_MID - acc_reg, '0, bbpd_pkg::K_DEG);
                mul_b = bbpd_pkg::MB_W'(span_mag);
                mul_start = cmd.start;
            end
            bbpd_pkg::STEP_D180: begin
                // x/180 = (x/4)/45 by reciprocal multiply
                mul_a = acc_reg >>> 2;
                mul_b = bbpd_pkg::K_R45;
                mul_start = cmd.start;
            end
            bbpd_pkg::STEP_SENS: begin
                div_n = MW'(sens_num);
                div_d = sens_pos ? 32'(sens_d * 5) : 32'd1;
                div_floor = 1'b1;
                div_start = cmd.start;
            end
            bbpd_pkg::STEP_PF: begin
                mul_a = MW'(25'(raw_reg) - 25'(pos_reg));
                mul_b = bbpd_pkg::MB_W'(pa_reg);
                mul_start = cmd.start;
            end
            bbpd_pkg::STEP_V1000: begin
                mul_a = MW'(25'(pos_reg) - 25'(prev_reg));
                mul_b = bbpd_pkg::K_MS;
                mul_start = cmd.start;
            end
            bbpd_pkg::STEP_VDIV: begin
                div_n = acc_reg;
                div_d = (el_reg == 16'd0) ? 32'd1 : 32'(el_reg);
                div_start = cmd.start;
            end
            bbpd_pkg::STEP_VF: begin
                mul_a = MW'(33'($signed(acc_reg[31:0])) - 33'(spd_reg));
                mul_b = bbpd_pkg::MB_W'(sa_reg);
                mul_start = cmd.start;
            end
            default: ;
        endcase
    end

    bbpd_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .product (mul_p),
        .done    (mul_done)
    );

    bbpd_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (div_start),
        .floor_mode (div_floor),
        .num        (div_n),
        .den        (div_d),
        .quotient   (div_q),
        .done       (div_done)
    );

    // angle = trunc(p*G / 2^40)
    logic signed [MW-1:0] mul_neg, angle;
    assign mul_neg = -mul_p;
    assign angle = mul_p[MW-1] ? -$signed({40'b0, mul_neg[MW-1:40]})
                               : $signed({40'b0, mul_p[MW-1:40]});

    logic signed [MW-1:0] duty_lo, duty_hi, duty_raw, q180;
    assign q180     = $signed({28'b0, mul_p[MW-1:28]});
    assign duty_lo  = (dmin_reg <= dmax_reg) ? MW'(dmin_reg) : MW'(dmax_reg);
    assign duty_hi  = (dmin_reg <= dmax_reg) ? MW'(dmax_reg) : MW'(dmin_reg);
    assign duty_raw = MW'(dmin_reg) + (span[16] ? -q180 : q180);

    logic signed [MW-1:0] pf_sum, vf_sum;
    assign pf_sum = MW'(pos_reg) + (mul_p >>> 16);
    assign vf_sum = MW'(spd_reg) + (mul_p >>> 16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            prev_reg <= '0;
            spd_reg  <= '0;
        end else if ((mul_done || div_done) && step_reg == bbpd_pkg::STEP_PF) begin
            if (!src_reg) begin
                pos_reg <= 24'(sat_s(pf_sum, P24_MIN, P24_MAX));
            end else if (extv_reg) begin
                pos_reg <= ext_reg;
            end
        end else if ((mul_done || div_done) && step_reg == bbpd_pkg::STEP_VDIV) begin
            prev_reg <= pos_reg;
        end else if ((mul_done || div_done) && step_reg == bbpd_pkg::STEP_VF) begin
            spd_reg <= 32'(sat_s(vf_sum, S32_MIN, S32_MAX));
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            adc_reg  <= adc_sample;
            el_reg   <= elapsed_ms;
            ext_reg  <= ext_position;
            extv_reg <= ext_valid;
        end
        if (cmd.start) begin
            step_reg <= cmd.step;
        end
        if (mul_done || div_done) begin
            case (step_reg)
                bbpd_pkg::STEP_TD:    acc_reg <= mul_p;
                bbpd_pkg::STEP_KP:    acc_reg <= sat_s(mul_p, -bbpd_pkg::ANGLE_SAT,
                                                       bbpd_pkg::ANGLE_SAT);
                bbpd_pkg::STEP_G:     acc_reg <= angle;
                bbpd_pkg::STEP_SPAN:  acc_reg <= mul_p;
                bbpd_pkg::STEP_D180:  duty_reg <= 16'(sat_s(duty_raw, duty_lo, duty_hi));
                bbpd_pkg::STEP_SENS:  raw_reg <= sens_pos ? 24'(sat_s(div_q, P24_MIN, P24_MAX))
                                                          : 24'(P24_MAX);
                bbpd_pkg::STEP_V1000: acc_reg <= mul_p;
                bbpd_pkg::STEP_VDIV:  acc_reg <= sat_s(div_q, S32_MIN, S32_MAX);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data_reg <= {spd_reg, pos_reg, duty_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign status   = '{done: mul_done | div_done, out_busy: out_valid_reg & ~m_tready};
endmodule
`default_nettype wire

[rtl/core/bbpd_ctrl.sv]
// Controller: sequences the arithmetic steps of one sample tick.
`timescale 1ns / 1ps
`default_nettype none
module bbpd_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output bbpd_pkg::cmd_t          cmd,
    input  wire bbpd_pkg::status_t  status
);
    bbpd_pkg::state_t state_reg, state_next;
    bbpd_pkg::step_t  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bbpd_pkg::ST_IDLE;
            step_reg  <= bbpd_pkg::STEP_TD;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.start  = 1'b0;
        cmd.finish = 1'b0;
        cmd.step   = step_reg;
        unique case (state_reg)
            bbpd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    step_next  = bbpd_pkg::STEP_TD;
                    state_next = bbpd_pkg::ST_ISSUE;
                end
            end
            bbpd_pkg::ST_ISSUE: begin
                cmd.start  = 1'b1;
                state_next = bbpd_pkg::ST_WAIT;
            end
            bbpd_pkg::ST_WAIT: begin
                if (status.done) begin
                    if (step_reg == bbpd_pkg::STEP_VF) begin
                        state_next = bbpd_pkg::ST_OUT;
                    end else begin
                        step_next  = bbpd_pkg::step_t'(step_reg + 1'b1);
                        state_next = bbpd_pkg::ST_ISSUE;
                    end
                end
            end
            bbpd_pkg::ST_OUT: begin
                // wait for the result register to free up
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = bbpd_pkg::ST_IDLE;
                end
            end
            default: state_next = bbpd_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[rtl/core/ball_beam_pd_servo_controller_top.sv]
// Top level of the ball-beam PD servo controller.
//
//  channel  direction  handshake            payload
//  s_       in         s_tvalid/s_tready    sample tick: adc, elapsed ms, ext position
//  m_       out        m_tvalid/m_tready    servo duty, filtered position, speed
//  cfg_     in         cfg_we               register index and data
//
// One request runs from acceptance to result as eight bit-serial multiplies and two
// restoring divides, each issued and then awaited until done, run one after another,
// and then the output register loads.
// The next request is taken the cycle after the result loads.
// Reset is synchronous, active low; no clearing pass is needed after it.
// A stalled output holds its data; the block then waits before loading the next result.
`timescale 1ns / 1ps
`default_nettype none
module ball_beam_pd_servo_controller_top #(
    parameter int ADC_BITS = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // adc_sample, elapsed_ms, ext_position, zero fill
    input  wire logic [((ADC_BITS+40+7)/8)*8-1:0] s_tdata,
    // ext_valid
    input  wire logic [0:0]                    s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // servo_duty, position_out, speed_out
    output logic [bbpd_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                          cfg_we,
    input  wire logic [2:0]                    cfg_addr,
    input  wire logic [bbpd_pkg::CFG_W-1:0]    cfg_wdata
);
    bbpd_pkg::cmd_t    cmd;
    bbpd_pkg::status_t status;

    bbpd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .status   (status)
    );

    bbpd_datapath #(
        .ADC_BITS (ADC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .adc_sample   (s_tdata[ADC_BITS-1:0]),
        .elapsed_ms   (s_tdata[ADC_BITS+15:ADC_BITS]),
        .ext_position (s_tdata[ADC_BITS+39:ADC_BITS+16]),
        .ext_valid    (s_tuser[0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );
endmodule
`default_nettype wire

[rtl/core/bbpd_checker.sv]
// Port-level checks for the ball-beam PD servo controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bbpd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [bbpd_pkg::OUT_W-1:0]    m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while one is in work");

    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a request in work");
endmodule

bind ball_beam_pd_servo_controller_top bbpd_checker u_bbpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

[test/tb_ball_beam_pd_servo_controller_top.sv]
// Self-checking testbench for the ball-beam PD servo controller top level.
`timescale 1ns / 1ps
module tb_ball_beam_pd_servo_controller_top;

    localparam int ADC_W = 12;
    localparam int SD_W = ((ADC_W + 40 + 7) / 8) * 8;
    localparam int WDOG_LIMIT = 20000;
    localparam longint P_MAX = 64'sd8388607;
    localparam longint P_MIN = -64'sd8388608;
    localparam longint V_MAX = 64'sd2147483647;
    localparam longint V_MIN = -64'sd2147483648;
    localparam longint ANG_SAT = 64'sd4398046511104;
    localparam longint G_MUL = 64'sd642908;

    typedef struct {
        logic [11:0] adc;
        logic [15:0] ms;
        logic [23:0] ext;
        logic        ext_ok;
    } tick_t;

    typedef struct {
        logic [15:0] duty;
        logic [23:0] pos;
        logic [31:0] spd;
    } servo_t;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [SD_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [bbpd_pkg::OUT_W-1:0] m_tdata;
    logic cfg_we;
    logic [2:0] cfg_addr;
    logic [bbpd_pkg::CFG_W-1:0] cfg_wdata;

    ball_beam_pd_servo_controller_top #(.ADC_BITS(ADC_W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    // predictor copy of registers and state
    longint set_pos;
    longint kp, td, a_pos, a_spd, src, dmin, dmax;
    longint f_pos, p_pos, f_spd;

    tick_t tick_q[$];
    servo_t servo_q[$];
    int errors;
    int idle_cnt;
    bit quiet;       // no random idling
    bit hold_req;    // long receiver hold-off requested
    int hold_left;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint fl_shr(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint tr_shr(longint x, int s);
        return x >= 0 ? (x >>> s) : -((-x) >>> s);
    endfunction

    function automatic longint lowpass(longint x, longint tgt, longint a, longint lo,
                                       longint hi);
        return clip(x + fl_shr((tgt - x) * a, 16), lo, hi);
    endfunction

    function automatic longint sensor_mm(longint adc);
        longint fs, d, num, q;
        fs = 4095;
        d = adc * 330 - 13 * fs;
        if (d <= 0) return P_MAX;
        num = 256 * (55500 * fs - 184 * d);
        q = num / (5 * d);
        if ((num % (5 * d)) != 0 && num < 0) q = q - 1;
        return clip(q, P_MIN, P_MAX);
    endfunction

    function automatic longint servo_duty_of();
        longint e, d20, p, ang, lo, hi, duty, t;
        e = set_pos - f_pos;
        d20 = e * 4096 - f_spd * td;
        p = clip(fl_shr(d20, 12) * kp, -ANG_SAT, ANG_SAT);
        ang = tr_shr(p * G_MUL, 40);
        lo = dmin;
        hi = dmax;
        duty = lo + (hi - lo) * (88 - ang) / 180;
        if (lo > hi) begin
            t = lo; lo = hi; hi = t;
        end
        return clip(duty, lo, hi);
    endfunction

    function automatic servo_t servo_step(tick_t t);
        servo_t r;
        longint ms, raw;
        r.duty = 16'(servo_duty_of());
        if (src == 0) begin
            f_pos = lowpass(f_pos, sensor_mm(longint'(t.adc)), a_pos, P_MIN, P_MAX);
        end else if (t.ext_ok) begin
            f_pos = longint'($signed(t.ext));
        end
        ms = t.ms == 0 ? 1 : longint'(t.ms);
        raw = clip((f_pos - p_pos) * 1000 / ms, V_MIN, V_MAX);
        p_pos = f_pos;
        f_spd = lowpass(f_spd, raw, a_spd, V_MIN, V_MAX);
        r.pos = 24'(f_pos);
        r.spd = 32'(f_spd);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (tick_q.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
                s_tdata <= SD_W'({tick_q[0].ext, tick_q[0].ms, tick_q[0].adc});
                s_tuser <= tick_q[0].ext_ok;
                servo_q.push_back(servo_step(tick_q[0]));
                void'(tick_q.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver readiness, with a long counted hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            m_tready <= 1'b0;
            hold_left <= 3000;
        end else begin
            m_tready <= quiet || $urandom_range(99) >= 16;
        end
    end

    // monitor
    always @(posedge aclk) begin
        servo_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (servo_q.size() == 0) begin
                report("unexpected result", m_tdata[31:0], 0);
            end else begin
                w = servo_q.pop_front();
                if (m_tdata[15:0] !== w.duty) report("servo_duty", m_tdata[15:0], w.duty);
                if (m_tdata[39:16] !== w.pos) report("position", m_tdata[39:16], w.pos);
                if (m_tdata[71:40] !== w.spd) report("speed", m_tdata[71:40], w.spd);
            end
        end
    end

    // watchdog on accepted traffic
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
            if (idle_cnt == WDOG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(bbpd_pkg::cfg_idx_t idx, longint val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= bbpd_pkg::CFG_W'(val);
        case (idx)
            bbpd_pkg::CFG_DESIRED:   set_pos = longint'($signed(24'(val)));
            bbpd_pkg::CFG_KP:        kp = val & 16'hFFFF;
            bbpd_pkg::CFG_TD:        td = val & 16'hFFFF;
            bbpd_pkg::CFG_POS_ALPHA: a_pos = val & 16'hFFFF;
            bbpd_pkg::CFG_SPD_ALPHA: a_spd = val & 16'hFFFF;
            bbpd_pkg::CFG_SOURCE:    src = val & 1;
            bbpd_pkg::CFG_DUTY_MIN:  dmin = val & 16'hFFFF;
            bbpd_pkg::CFG_DUTY_MAX:  dmax = val & 16'hFFFF;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_tick(logic [11:0] adc, logic [15:0] ms, logic [23:0] ext, logic ok);
        tick_t t;
        t.adc = adc;
        t.ms = ms;
        t.ext = ext;
        t.ext_ok = ok;
        tick_q.push_back(t);
    endtask

    task automatic add_random(int n);
        logic [15:0] ms;
        repeat (n) begin
            case ($urandom_range(3))
                0: ms = 16'($urandom_range(1, 3));
                1: ms = 16'($urandom);
                default: ms = 16'($urandom_range(1, 40));
            endcase
            add_tick(12'($urandom), ms, 24'($urandom), 1'($urandom));
        end
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || servo_q.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        set_pos = 25600; kp = 2294; td = 2458; a_pos = 10923; a_spd = 6554;
        src = 0; dmin = 1638; dmax = 8192;
        f_pos = 0; p_pos = 0; f_spd = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: sensor extremes, zero divisor region, elapsed extremes
        add_tick(12'd0, 16'd1, 24'h7FFFFF, 1'b1);
        add_tick(12'd4095, 16'd1, 24'h0, 1'b0);
        add_tick(12'd161, 16'd0, 24'h0, 1'b0);
        add_tick(12'd162, 16'd65535, 24'h0, 1'b0);
        add_tick(12'd1, 16'd1, 24'h0, 1'b0);
        add_tick(12'd2048, 16'd10, 24'h800000, 1'b1);
        drain();
        // external source: valid, held, extremes
        write_reg(bbpd_pkg::CFG_SOURCE, 1);
        write_reg(bbpd_pkg::CFG_POS_ALPHA, 65535);
        write_reg(bbpd_pkg::CFG_SPD_ALPHA, 65535);
        add_tick(12'hFFF, 16'd1, 24'h7FFFFF, 1'b1);
        add_tick(12'h0, 16'd1, 24'h800000, 1'b1);
        add_tick(12'h0, 16'd0, 24'h123456, 1'b0);
        add_tick(12'h0, 16'd1, 24'h7FFFFF, 1'b1);
        add_tick(12'h0, 16'd65535, 24'h000100, 1'b1);
        drain();
        // swapped duty limits, extreme gains
        write_reg(bbpd_pkg::CFG_DUTY_MIN, 65535);
        write_reg(bbpd_pkg::CFG_DUTY_MAX, 0);
        write_reg(bbpd_pkg::CFG_KP, 65535);
        write_reg(bbpd_pkg::CFG_TD, 65535);
        write_reg(bbpd_pkg::CFG_DESIRED, -8388608);
        add_tick(12'h0, 16'd1, 24'h7FFFFF, 1'b1);
        add_tick(12'h0, 16'd1, 24'h800000, 1'b1);
        add_tick(12'h0, 16'd1, 24'h0, 1'b1);
        drain();
        write_reg(bbpd_pkg::CFG_DESIRED, 8388607);
        add_tick(12'h0, 16'd1, 24'h800000, 1'b1);
        drain();
        write_reg(bbpd_pkg::CFG_KP, 0);
        write_reg(bbpd_pkg::CFG_TD, 0);
        write_reg(bbpd_pkg::CFG_POS_ALPHA, 0);
        write_reg(bbpd_pkg::CFG_SPD_ALPHA, 0);
        write_reg(bbpd_pkg::CFG_SOURCE, 0);
        add_tick(12'd3000, 16'd5, 24'h0, 1'b0);
        drain();

        // random phases with assorted settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(bbpd_pkg::CFG_DESIRED,
                      ph == 5 ? 25600 : longint'($signed(24'($urandom))));
            write_reg(bbpd_pkg::CFG_KP, ph == 5 ? 2294 : $urandom_range(65535));
            write_reg(bbpd_pkg::CFG_TD, ph == 5 ? 2458 : $urandom_range(65535));
            write_reg(bbpd_pkg::CFG_POS_ALPHA, $urandom_range(65535));
            write_reg(bbpd_pkg::CFG_SPD_ALPHA, $urandom_range(65535));
            write_reg(bbpd_pkg::CFG_SOURCE, ph % 2);
            write_reg(bbpd_pkg::CFG_DUTY_MIN, ph == 2 ? 9000 : 1638);
            write_reg(bbpd_pkg::CFG_DUTY_MAX, ph == 2 ? 1000 : $urandom_range(65535));
            quiet = (ph == 3);
            add_random(90);
            if (ph == 1) begin
                // long receiver hold-off while the sender keeps offering
                hold_req = 1'b1;
                wait (hold_left > 0);
                hold_req = 1'b0;
            end
            drain();
        end

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/core/bbpd_pkg.sv
rtl/core/bbpd_mul.sv
rtl/core/bbpd_div.sv
rtl/core/bbpd_datapath.sv
rtl/core/bbpd_ctrl.sv
rtl/core/ball_beam_pd_servo_controller_top.sv
rtl/core/bbpd_checker.sv
test/tb_ball_beam_pd_servo_controller_top.sv
